FILE: hdl/assert_macros.svh
// assertion macros shared by the mapper rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on the rising edge, off during reset
`define AVM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("avm assertion failed");

// next-cycle implication
`define AVM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("avm assertion failed");

`endif

FILE: hdl/avm_pkg.sv
// shared types and constants of the adc to volume mapper
// no dependencies
`timescale 1ns / 1ps

package avm_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int OUT_BITS        = 16;
    localparam int CFG_IDX_BITS    = 3;
    localparam int THR_DIV         = 100;

    localparam logic signed [OUT_BITS-1:0] OUT_LOW_RST  = -16'sd6000;
    localparam logic signed [OUT_BITS-1:0] OUT_HIGH_RST = 16'sd0;
    localparam logic [OUT_BITS-1:0]        PERIOD_RST   = 16'd40;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ADC_LOW   = 3'd0,
        CFG_ADC_HIGH  = 3'd1,
        CFG_REVERSE   = 3'd2,
        CFG_OUT_LOW   = 3'd3,
        CFG_OUT_HIGH  = 3'd4,
        CFG_PERIOD    = 3'd5,
        CFG_MINMAX    = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_THR,
        S_THR_WAIT,
        S_DECIDE,
        S_MUL,
        S_DIV_MAP,
        S_MAP_WAIT,
        S_FINISH
    } t_state;

    // configuration fields whose width does not follow the sample width
    typedef struct packed {
        logic                       reverse;
        logic signed [OUT_BITS-1:0] out_low;
        logic signed [OUT_BITS-1:0] out_high;
        logic [OUT_BITS-1:0]        refresh_period;
        logic                       minmax_en;
    } t_cfg;

endpackage

FILE: hdl/avm_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on avm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module avm_div
    import avm_pkg::*;
#(
    parameter int DW = SAMPLE_BITS_DEF + OUT_BITS,
    parameter int VW = SAMPLE_BITS_DEF,
    parameter int CW = $clog2(SAMPLE_BITS_DEF + OUT_BITS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    input  logic [CW-1:0] i_iters,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [VW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_dq, n_dq;
    logic [VW-1:0] r_den, n_den;
    logic [VW:0]   trial;
    logic          ge;

    // dividend bits leave at the top, quotient bits enter at the bottom
    assign trial = {r_rem, r_dq[DW-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dq   = r_dq;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_iters;
            n_rem  = '0;
            n_dq   = i_dividend;
            n_den  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? VW'(trial - {1'b0, r_den}) : trial[VW-1:0];
            n_dq  = {r_dq[DW-2:0], ge};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dq  <= n_dq;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_dq;

    `AVM_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_start, !r_busy)
    `AVM_ASSERT_IMP(a_busy_cnt, i_clk, i_rst_n, r_busy, r_cnt != '0)
    `AVM_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done && !i_start, !r_done && !r_busy)

endmodule

FILE: hdl/avm_seq.sv
// sequencer, item state and output register of the mapper
// depends on avm_pkg and assert_macros.svh; drives the shared divider
`timescale 1ns / 1ps
`include "assert_macros.svh"

module avm_seq
    import avm_pkg::*;
#(
    parameter int SB = SAMPLE_BITS_DEF,
    parameter int DW = SAMPLE_BITS_DEF + OUT_BITS,
    parameter int CW = $clog2(SAMPLE_BITS_DEF + OUT_BITS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [SB-1:0]              i_sample,
    input  logic                       i_sample_ok,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_volume_write,
    output logic signed [OUT_BITS-1:0] o_volume,
    output logic                       o_seen_valid,
    output logic [SB-1:0]              o_seen_min,
    output logic [SB-1:0]              o_seen_max,
    input  logic [SB-1:0]              i_adc_low,
    input  logic [SB-1:0]              i_adc_high,
    input  t_cfg                       i_cfg,
    output logic                       o_div_start,
    output logic [DW-1:0]              o_div_dividend,
    output logic [SB-1:0]              o_div_divisor,
    output logic [CW-1:0]              o_div_iters,
    input  logic                       i_div_done,
    input  logic [DW-1:0]              i_div_quot
);

    t_state r_state, n_state;

    logic [SB-1:0]       r_sample, n_sample;
    logic                r_ok, n_ok;
    logic                r_issue, n_issue;
    logic                r_neg, n_neg;
    logic [DW-1:0]       r_prod, n_prod;
    logic [OUT_BITS-1:0] r_vol_new, n_vol_new;

    logic [SB-1:0]       r_last, n_last;
    logic                r_last_valid, n_last_valid;
    logic [OUT_BITS-1:0] r_refresh_cnt, n_refresh_cnt;
    logic [SB-1:0]       r_seen_min, n_seen_min;
    logic [SB-1:0]       r_seen_max, n_seen_max;
    logic                r_seen_flag, n_seen_flag;
    logic [OUT_BITS-1:0] r_vol, n_vol;

    logic                r_out_valid, n_out_valid;
    logic                r_out_write, n_out_write;
    logic [OUT_BITS-1:0] r_out_vol, n_out_vol;
    logic                r_out_seen, n_out_seen;
    logic [SB-1:0]       r_out_min, n_out_min;
    logic [SB-1:0]       r_out_max, n_out_max;

    logic                inv;
    logic [SB-1:0]       absdiff;
    logic [SB-1:0]       thr;
    logic [SB-1:0]       delta;
    logic                moved;
    logic                issue_c;
    logic [OUT_BITS-1:0] o0;
    logic [OUT_BITS-1:0] o1;
    logic                below;
    logic                above;
    logic                flat;
    logic                bound_c;
    logic [OUT_BITS:0]   span;
    logic [OUT_BITS:0]   span_abs;
    logic [SB-1:0]       offs;
    logic [OUT_BITS:0]   qmag;
    logic [OUT_BITS:0]   map_sum;
    logic [OUT_BITS:0]   cnt_inc;
    logic                out_free;
    logic                accept;
    logic                fin;
    logic                wr;

    // deadband threshold is |adc_high - adc_low| / 100, sign handled apart
    assign inv     = i_adc_high < i_adc_low;
    assign absdiff = inv ? (i_adc_low - i_adc_high) : (i_adc_high - i_adc_low);
    assign thr     = i_div_quot[SB-1:0];
    assign delta   = (r_sample >= r_last) ? (r_sample - r_last) : (r_last - r_sample);
    // with inverted bounds the threshold is minus thr, so only a zero match fails
    assign moved   = inv ? ((delta != '0) || (thr != '0)) : (delta > thr);
    assign issue_c = moved || !r_last_valid || (r_refresh_cnt == i_cfg.refresh_period);

    assign o0 = i_cfg.reverse ? i_cfg.out_high : i_cfg.out_low;
    assign o1 = i_cfg.reverse ? i_cfg.out_low : i_cfg.out_high;

    assign below   = r_sample < i_adc_low;
    assign above   = r_sample > i_adc_high;
    assign flat    = i_adc_high == i_adc_low;
    assign bound_c = below || above || flat;

    assign span     = {o1[OUT_BITS-1], o1} - {o0[OUT_BITS-1], o0};
    assign span_abs = span[OUT_BITS] ? ((OUT_BITS+1)'(0) - span) : span;
    assign offs     = r_sample - i_adc_low;

    // quotient never exceeds the output span, so 16 bits hold it
    assign qmag    = {1'b0, i_div_quot[OUT_BITS-1:0]};
    assign map_sum = {o0[OUT_BITS-1], o0} + (r_neg ? ((OUT_BITS+1)'(0) - qmag) : qmag);

    assign cnt_inc  = {1'b0, r_refresh_cnt} + (OUT_BITS+1)'(1);
    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign fin      = (r_state == S_FINISH) && out_free;
    assign wr       = r_ok && !i_cfg.minmax_en && r_issue;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_THR;
            end
            S_THR: begin
                if (!r_ok || i_cfg.minmax_en) n_state = S_FINISH;
                else                          n_state = S_THR_WAIT;
            end
            S_THR_WAIT: begin
                if (i_div_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!issue_c || bound_c) n_state = S_FINISH;
                else                     n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_DIV_MAP;
            end
            S_DIV_MAP: begin
                n_state = S_MAP_WAIT;
            end
            S_MAP_WAIT: begin
                if (i_div_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_stall     = 1'b1;
        o_div_start    = 1'b0;
        o_div_dividend = {absdiff, {OUT_BITS{1'b0}}};
        o_div_divisor  = SB'(THR_DIV);
        o_div_iters    = CW'(SB);
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_THR: begin
                o_div_start = r_ok && !i_cfg.minmax_en;
            end
            S_DIV_MAP: begin
                o_div_start    = 1'b1;
                o_div_dividend = r_prod;
                o_div_divisor  = i_adc_high - i_adc_low;
                o_div_iters    = CW'(DW);
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_sample      = r_sample;
        n_ok          = r_ok;
        n_issue       = r_issue;
        n_neg         = r_neg;
        n_prod        = r_prod;
        n_vol_new     = r_vol_new;
        n_last        = r_last;
        n_last_valid  = r_last_valid;
        n_refresh_cnt = r_refresh_cnt;
        n_seen_min    = r_seen_min;
        n_seen_max    = r_seen_max;
        n_seen_flag   = r_seen_flag;
        n_vol         = r_vol;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_write   = r_out_write;
        n_out_vol     = r_out_vol;
        n_out_seen    = r_out_seen;
        n_out_min     = r_out_min;
        n_out_max     = r_out_max;

        if (accept) begin
            n_sample = i_sample;
            n_ok     = i_sample_ok;
            n_issue  = 1'b0;
        end

        if (r_state == S_DECIDE) begin
            n_issue   = issue_c;
            // below adc_low wins even when inverted bounds also make it above adc_high
            n_vol_new = (above && !below) ? o1 : o0;
        end

        if (r_state == S_MUL) begin
            n_prod = DW'(offs) * DW'(span_abs[OUT_BITS-1:0]);
            n_neg  = span[OUT_BITS];
        end

        if ((r_state == S_MAP_WAIT) && i_div_done) begin
            n_vol_new = map_sum[OUT_BITS-1:0];
        end

        if (fin) begin
            if (r_ok && i_cfg.minmax_en) begin
                if (!r_seen_flag) begin
                    n_seen_min  = r_sample;
                    n_seen_max  = r_sample;
                    n_seen_flag = 1'b1;
                end else begin
                    if (r_sample < r_seen_min) n_seen_min = r_sample;
                    if (r_sample > r_seen_max) n_seen_max = r_sample;
                end
            end
            if (wr) begin
                n_last       = r_sample;
                n_last_valid = 1'b1;
                n_vol        = r_vol_new;
            end
            // counter wraps once it passes the period
            if (cnt_inc > {1'b0, i_cfg.refresh_period}) n_refresh_cnt = '0;
            else                                        n_refresh_cnt = cnt_inc[OUT_BITS-1:0];

            n_out_valid = 1'b1;
            n_out_write = wr;
            n_out_vol   = n_vol;
            n_out_seen  = n_seen_flag;
            n_out_min   = n_seen_min;
            n_out_max   = n_seen_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_last        <= '0;
            r_last_valid  <= 1'b0;
            r_refresh_cnt <= '0;
            r_seen_min    <= '0;
            r_seen_max    <= '0;
            r_seen_flag   <= 1'b0;
            r_vol         <= '0;
            r_issue       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_last        <= n_last;
            r_last_valid  <= n_last_valid;
            r_refresh_cnt <= n_refresh_cnt;
            r_seen_min    <= n_seen_min;
            r_seen_max    <= n_seen_max;
            r_seen_flag   <= n_seen_flag;
            r_vol         <= n_vol;
            r_issue       <= n_issue;
        end
        r_sample    <= n_sample;
        r_ok        <= n_ok;
        r_neg       <= n_neg;
        r_prod      <= n_prod;
        r_vol_new   <= n_vol_new;
        r_out_write <= n_out_write;
        r_out_vol   <= n_out_vol;
        r_out_seen  <= n_out_seen;
        r_out_min   <= n_out_min;
        r_out_max   <= n_out_max;
    end

    assign o_out_valid    = r_out_valid;
    assign o_volume_write = r_out_write;
    assign o_volume       = r_out_vol;
    assign o_seen_valid   = r_out_seen;
    assign o_seen_min     = r_out_min;
    assign o_seen_max     = r_out_max;

    `AVM_ASSERT_IMP(a_minmax_order, i_clk, i_rst_n, r_seen_flag, r_seen_min <= r_seen_max)
    `AVM_ASSERT_IMP(a_map_issue, i_clk, i_rst_n, r_state == S_MAP_WAIT, r_issue)
    `AVM_ASSERT_NXT(a_finish_idle, i_clk, i_rst_n, fin, r_state == S_IDLE && r_out_valid)
    `AVM_ASSERT_IMP(a_write_used, i_clk, i_rst_n, r_out_valid && r_out_write, r_last_valid)

endmodule

FILE: hdl/adc_to_volume_mapper.sv
// path: the threshold divide (SAMPLE_BITS quotient bits) runs first, then a mapped volume
// takes a multiply and a map divide (SAMPLE_BITS+16 quotient bits) before the result; a
// clamped or not issued volume skips both, min/max mode or a failed read skips all three
// throughput: one transaction at a time, a new one taken the cycle after the result
// loads; a stalled output holds the result in the finish state and blocks new input
// reset: synchronous active low; control and config registers return to defaults only
`timescale 1ns / 1ps

module adc_to_volume_mapper
    import avm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [OUT_BITS-1:0]        i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [SAMPLE_BITS-1:0]     i_sample,
    input  logic                       i_sample_ok,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_volume_write,
    output logic signed [OUT_BITS-1:0] o_volume,
    output logic                       o_seen_valid,
    output logic [SAMPLE_BITS-1:0]     o_seen_min,
    output logic [SAMPLE_BITS-1:0]     o_seen_max
);

    localparam int DW = SAMPLE_BITS + OUT_BITS;
    localparam int CW = $clog2(DW + 1);

    logic [SAMPLE_BITS-1:0] r_adc_low, n_adc_low;
    logic [SAMPLE_BITS-1:0] r_adc_high, n_adc_high;
    t_cfg                   r_cfg, n_cfg;

    logic                   div_start;
    logic [DW-1:0]          div_dividend;
    logic [SAMPLE_BITS-1:0] div_divisor;
    logic [CW-1:0]          div_iters;
    logic                   div_done;
    logic [DW-1:0]          div_quot;

    always_comb begin
        n_adc_low  = r_adc_low;
        n_adc_high = r_adc_high;
        n_cfg      = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ADC_LOW:   n_adc_low            = i_cfg_data[SAMPLE_BITS-1:0];
                CFG_ADC_HIGH:  n_adc_high           = i_cfg_data[SAMPLE_BITS-1:0];
                CFG_REVERSE:   n_cfg.reverse        = i_cfg_data[0];
                CFG_OUT_LOW:   n_cfg.out_low        = i_cfg_data;
                CFG_OUT_HIGH:  n_cfg.out_high       = i_cfg_data;
                CFG_PERIOD:    n_cfg.refresh_period = i_cfg_data;
                CFG_MINMAX:    n_cfg.minmax_en      = i_cfg_data[0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_low            <= '0;
            r_adc_high           <= '1;
            r_cfg.reverse        <= 1'b0;
            r_cfg.out_low        <= OUT_LOW_RST;
            r_cfg.out_high       <= OUT_HIGH_RST;
            r_cfg.refresh_period <= PERIOD_RST;
            r_cfg.minmax_en      <= 1'b0;
        end else begin
            r_adc_low  <= n_adc_low;
            r_adc_high <= n_adc_high;
            r_cfg      <= n_cfg;
        end
    end

    avm_seq #(
        .SB (SAMPLE_BITS),
        .DW (DW),
        .CW (CW)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_sample_ok    (i_sample_ok),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_volume_write (o_volume_write),
        .o_volume       (o_volume),
        .o_seen_valid   (o_seen_valid),
        .o_seen_min     (o_seen_min),
        .o_seen_max     (o_seen_max),
        .i_adc_low      (r_adc_low),
        .i_adc_high     (r_adc_high),
        .i_cfg          (r_cfg),
        .o_div_start    (div_start),
        .o_div_dividend (div_dividend),
        .o_div_divisor  (div_divisor),
        .o_div_iters    (div_iters),
        .i_div_done     (div_done),
        .i_div_quot     (div_quot)
    );

    avm_div #(
        .DW (DW),
        .VW (SAMPLE_BITS),
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_iters    (div_iters),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

endmodule
